@@ sv/nwm_pkg.sv @@
// ----------------------------------------------------------------------------
// nwm_pkg
// Shared types, constants and byte classifiers for the numeric word masker.
// ----------------------------------------------------------------------------
package nwm_pkg;

    localparam logic [7:0] CHAR_X = 8'h78;  // 'x'

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } out_item_t;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

@@ sv/nwm_ram.sv @@
// ----------------------------------------------------------------------------
// nwm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/numeric_word_masker.sv @@
// ----------------------------------------------------------------------------
// numeric_word_masker
// Buffers each word of a byte stream and replays it at the word boundary,
// masking all-digit words with 'x'. Overlong words pass through unchanged.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | nwm_pkg::in_item_t
//  out     | output    | out_valid / out_ready| nwm_pkg::out_item_t
//
//  A byte that only enters the word store is taken without leaving ST_IDLE. A
//  byte that ends a word is transferred; each stored byte is then replayed by a
//  RAM read (ST_READ) and an output load (ST_SEND), one at a time through the
//  single read port, then any trailing byte follows (ST_TAIL); input waits.
//  Reset (rst_n low, asynchronous) clears counters and the sequencer; the
//  word store needs no clearing. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module numeric_word_masker #(
    parameter int WORD_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nwm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output nwm_pkg::out_item_t  out_data
);

    localparam int CW = $clog2(WORD_MAX + 1);
    localparam int AW = $clog2(WORD_MAX);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SEND = 4'b0100,
        ST_TAIL = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               all_dig_reg, all_dig_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      len_reg, len_next;
    logic               mask_reg, mask_next;
    logic               final_reg, final_next;
    logic               tail_reg, tail_next;
    logic [7:0]         char_reg, char_next;
    logic               le_reg, le_next;

    logic               out_valid_reg, out_valid_next;
    nwm_pkg::out_item_t out_data_reg, out_data_next;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    nwm_pkg::out_item_t out_load_data;
    logic               sp, dig, full;
    logic               ram_we, ram_re;
    logic [7:0]         ram_rdata;
    logic [CW-1:0]      idx_inc;
    logic               rep_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign sp   = nwm_pkg::is_space(in_data.char_in);
    assign dig  = nwm_pkg::is_digit(in_data.char_in);
    assign full = (count_reg == CW'(WORD_MAX));

    assign ram_we   = in_xfer && !sp && !ovf_reg && !full;
    assign ram_re   = (state_reg == ST_READ);
    assign idx_inc  = idx_reg + 1'b1;
    assign rep_last = (idx_inc == len_reg);

    nwm_ram #(
        .WIDTH (8),
        .DEPTH (WORD_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_data.char_in),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        all_dig_next  = all_dig_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        mask_next     = mask_reg;
        final_next    = final_reg;
        tail_next     = tail_reg;
        char_next     = char_reg;
        le_next       = le_reg;
        out_load      = 1'b0;
        out_load_data = '{char_out: char_reg, last_out: le_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    char_next  = in_data.char_in;
                    le_next    = in_data.line_end;
                    idx_next   = '0;
                    final_next = 1'b0;
                    mask_next  = 1'b0;
                    if (sp)
                    begin
                        len_next     = ovf_reg ? '0 : count_reg;
                        mask_next    = all_dig_reg;
                        tail_next    = 1'b1;
                        count_next   = '0;
                        all_dig_next = 1'b1;
                        ovf_next     = 1'b0;
                    end
                    else if (ovf_reg)
                    begin
                        len_next  = '0;
                        tail_next = 1'b1;
                    end
                    else if (full)
                    begin
                        // flush the stored part unchanged, rest streams through
                        len_next   = count_reg;
                        tail_next  = 1'b1;
                        count_next = '0;
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        len_next     = in_data.line_end ? count_reg + 1'b1 : '0;
                        mask_next    = all_dig_reg && dig;
                        final_next   = 1'b1;
                        tail_next    = 1'b0;
                        count_next   = count_reg + 1'b1;
                        all_dig_next = all_dig_reg && dig;
                    end
                    if (in_data.line_end)
                    begin
                        count_next   = '0;
                        all_dig_next = 1'b1;
                        ovf_next     = 1'b0;
                    end

                    if (len_next != '0)
                    begin
                        state_next = ST_READ;
                    end
                    else if (tail_next)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_data = '{char_out: mask_reg ? nwm_pkg::CHAR_X : ram_rdata,
                                      last_out: final_reg && rep_last};
                    idx_next      = idx_inc;
                    if (!rep_last)
                    begin
                        state_next = ST_READ;
                    end
                    else if (tail_reg)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);
        out_data_next  = out_load ? out_load_data : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            all_dig_reg   <= 1'b1;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            all_dig_reg   <= all_dig_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        final_reg    <= final_next;
        char_reg     <= char_next;
        le_reg       <= le_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/nwm_checker.sv @@
// ----------------------------------------------------------------------------
// nwm_checker
// Port-level checks for the numeric word masker, bound to the top level.
// ----------------------------------------------------------------------------
module nwm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input nwm_pkg::in_item_t   in_data,
    input logic                out_valid,
    input logic                out_ready,
    input nwm_pkg::out_item_t  out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out payload changed while stalled");

    // whitespace always produces at least the trailing byte, so input stalls
    a_space_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && nwm_pkg::is_space(in_data.char_in) |=> !in_ready)
        else $error("input ready right after whitespace transfer");

    // a line end always produces output, so input stalls
    a_line_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.line_end |=> !in_ready)
        else $error("input ready right after line end transfer");

endmodule

bind numeric_word_masker nwm_checker u_nwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ test/numeric_word_masker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// numeric_word_masker_test
// Feeds text lines into the masker and checks every output byte against a
// behavioral predictor that holds its own copy of the word store. It covers
// directed word classes, the full store and spill cases, random well-formed
// lines with some noise, long output back-pressure, and a final stretch
// with no idle cycles.
// ----------------------------------------------------------------------------
module numeric_word_masker_test;

    localparam int CLK_PERIOD   = 8;
    localparam int WORD_LEN     = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 4 * WORD_LEN + 16;
    localparam int MAX_PRINTED  = 40;

    localparam logic [7:0] SP = 8'h20;
    localparam logic [7:0] HT = 8'h09;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [7:0] VT = 8'h0B;
    localparam logic [7:0] FF = 8'h0C;
    localparam logic [7:0] CR = 8'h0D;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    nwm_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    nwm_pkg::out_item_t out_data;

    // predictor state
    logic [7:0]  held_word [WORD_LEN];
    int          held_len;
    bit          held_numeric;
    bit          held_spilled;

    nwm_pkg::out_item_t masked_stream_q[$];
    int          bytes_owed;
    int          items_sent;
    int          errors;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          hold_request;

    numeric_word_masker #(
        .WORD_MAX (WORD_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic bit ws_byte(input logic [7:0] c);
        case (c)
            SP, HT, LF, VT, FF, CR: return 1'b1;
            default:                return 1'b0;
        endcase
    endfunction

    function automatic bit dig_byte(input logic [7:0] c);
        return (c[7:4] == 4'h3) && (c[3:0] <= 4'd9);
    endfunction

    function automatic void queue_byte(input logic [7:0] c, input logic last);
        nwm_pkg::out_item_t r;
        r.char_out = c;
        r.last_out = last;
        masked_stream_q.push_back(r);
        bytes_owed++;
    endfunction

    function automatic void replay_held(input bit masked, input bit closes_line);
        for (int i = 0; i < held_len; i++)
            queue_byte(masked ? nwm_pkg::CHAR_X : held_word[i],
                       closes_line && (i == held_len - 1));
    endfunction

    function automatic void clear_held();
        held_len     = 0;
        held_numeric = 1'b1;
        held_spilled = 1'b0;
    endfunction

    function automatic void predict_masked_bytes(input logic [7:0] c, input logic le);
        if (ws_byte(c))
        begin
            if (!held_spilled)
                replay_held(held_numeric, 1'b0);
            queue_byte(c, le);
            clear_held();
        end
        else
        begin
            if (held_spilled)
                queue_byte(c, le);
            else if (held_len == WORD_LEN)
            begin
                // store full: flush it unmasked, then the word runs through
                replay_held(1'b0, 1'b0);
                held_len     = 0;
                held_spilled = 1'b1;
                queue_byte(c, le);
            end
            else
            begin
                held_word[held_len] = c;
                held_len++;
                if (!dig_byte(c))
                    held_numeric = 1'b0;
                if (le)
                    replay_held(held_numeric, 1'b1);
            end
            if (le)
                clear_held();
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic le);
        nwm_pkg::in_item_t item;
        int gap;
        item.char_in  = c;
        item.line_end = le;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_masked_bytes(c, le);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit end_line);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], end_line && (k == s.len() - 1));
    endtask

    // kind 0: digit, otherwise any non-whitespace byte
    function automatic logic [7:0] word_byte(input int kind);
        logic [7:0] c;
        if (kind == 0)
            return 8'h30 + 8'($urandom_range(0, 9));
        do
            c = 8'($urandom_range(0, 255));
        while (ws_byte(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0:       return SP;
            1:       return HT;
            2:       return LF;
            3:       return VT;
            4:       return FF;
            default: return CR;
        endcase
    endfunction

    function automatic int pick_word_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        else if (r < 14)
            return $urandom_range(1, 8);
        else if (r < 17)
            return $urandom_range(9, WORD_LEN);
        return $urandom_range(WORD_LEN - 1, WORD_LEN + 8);
    endfunction

    task automatic send_run(input int n, input int kind, input bit end_line);
        for (int k = 0; k < n; k++)
            send_byte(word_byte(kind), end_line && (k == n - 1));
    endtask

    task automatic send_random_line();
        logic [7:0] line_q[$];
        int n_words;
        int len;
        int kind;
        int odd_pos;
        n_words = $urandom_range(1, 6);
        for (int w = 0; w < n_words; w++)
        begin
            len     = pick_word_len();
            kind    = $urandom_range(0, 19);
            odd_pos = $urandom_range(0, (len > 0) ? len - 1 : 0);
            for (int k = 0; k < len; k++)
            begin
                // near-numeric words: digits with one byte just outside '0'..'9'
                if (kind >= 16 && k == odd_pos)
                    line_q.push_back($urandom_range(0, 1) ? 8'h2F : 8'h3A);
                else
                    line_q.push_back(word_byte((kind < 10 || kind >= 16) ? 0 : 1));
            end
            if (w < n_words - 1 || $urandom_range(0, 1))
                line_q.push_back(pick_ws());
        end
        if (line_q.size() == 0)
            line_q.push_back(pick_ws());
        foreach (line_q[i])
            send_byte(line_q[i], i == line_q.size() - 1);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        wait (bytes_owed == 0);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_word_classes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_text("12", 1'b0);
        send_byte(SP, 1'b0);
        send_text("ab", 1'b0);
        send_byte(HT, 1'b0);
        send_byte(HT, 1'b0);            // empty word
        send_text("09", 1'b0);
        send_byte(VT, 1'b0);
        send_text("/:", 1'b0);          // neighbors of the digit range
        send_byte(FF, 1'b0);
        send_text("5", 1'b0);
        send_byte(CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h0E, 1'b0);
        send_byte(LF, 1'b0);
        send_text("78", 1'b1);          // numeric word closed by line end
        send_byte(SP, 1'b1);            // whitespace alone on a line
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(SP, 1'b0);
        send_text("3", 1'b1);
    endtask

    task automatic test_full_store();
        send_run(WORD_LEN, 0, 1'b0);
        send_byte(SP, 1'b0);
        send_run(WORD_LEN, 0, 1'b1);
        send_run(WORD_LEN + 3, 0, 1'b0);
        send_byte(HT, 1'b0);
        send_run(WORD_LEN + 1, 1, 1'b1);
        send_run(WORD_LEN + 2, 0, 1'b0);
        send_byte(LF, 1'b1);
    endtask

    task automatic test_random_lines(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: raw bytes, stray line ends
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
                send_random_line();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 48; i++)
        begin
            if (i % 6 == 5)
                send_byte(pick_ws(), i == 47);
            else
                send_byte(word_byte((i / 6) % 2), i == 47);
        end
        pause_until_drained();
        rx_idle_on = 1'b1;
        send_random_line();
        pause_until_drained();
    endtask

    task automatic test_steady_stream(input int n_items);
        int start;
        start      = items_sent;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (items_sent - start < n_items)
            send_random_line();
    endtask

    // ------------------------------------------------------------------
    // receive side and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    initial
    begin : rx_side
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_out
        nwm_pkg::out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (masked_stream_q.size() == 0)
                report_mismatch($sformatf("unexpected transfer char %h last %b",
                                          out_data.char_out, out_data.last_out));
            else
            begin
                want = masked_stream_q.pop_front();
                bytes_owed--;
                if (out_data.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out %h, expected %h",
                                              out_data.char_out, want.char_out));
                if (out_data.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %b, expected %b (char %h)",
                                              out_data.last_out, want.last_out,
                                              want.char_out));
            end
        end
    end

    // no transfer on either side for too long means the block is stuck
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        errors       = 0;
        bytes_owed   = 0;
        items_sent   = 0;
        hold_request = 0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        clear_held();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word_classes();
        test_full_store();
        test_random_lines(120);
        test_output_backpressure();
        test_steady_stream(80);

        in_valid <= 1'b0;
        wait (bytes_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/nwm_pkg.sv
sv/nwm_ram.sv
sv/numeric_word_masker.sv
sv/nwm_checker.sv
test/numeric_word_masker_test.sv
